// ===== src/listen_duration_encoder_macros.svh =====
// ---------------------------------------------------------------------------
// Listen duration encoder assertion macros
// Wrap concurrent assertions so that synthesis sees nothing.
// ---------------------------------------------------------------------------
`ifndef LISTEN_DURATION_ENCODER_MACROS_SVH
`define LISTEN_DURATION_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define LDE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LDE_ASSERT(lbl, clk, rst_n, prop, msg)
`define LDE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/lde_pkg.sv =====
// ---------------------------------------------------------------------------
// Listen duration encoder package
// Word types, time unit codes and the constants of the quantiser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lde_pkg;

    typedef enum logic [1:0] {
        UNIT_64     = 2'd0,
        UNIT_4100   = 2'd1,
        UNIT_262000 = 2'd2
    } t_unit;

    typedef struct packed {
        logic [31:0] rx_request_us;
        logic [31:0] idle_request_us;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [1:0]  rx_unit;
        logic [7:0]  rx_count;
        logic [1:0]  idle_unit;
        logic [7:0]  idle_count;
        logic [25:0] rx_actual_us;
        logic [25:0] idle_actual_us;
        logic [17:0] cycle_ms;
    } t_res;

    typedef struct packed {
        logic        ok;
        t_unit       unit;
        logic [7:0]  count;
        logic [25:0] actual;
    } t_quant;

    // largest duration that still rounds to a count below 256
    localparam logic [31:0] FIT_MAX_64     = 32'd16352;
    localparam logic [31:0] FIT_MAX_4100   = 32'd1047550;
    localparam logic [31:0] FIT_MAX_262000 = 32'd66941000;

    localparam logic [9:0]  US_PER_MS = 10'd1000;
    // floor(2^37 / 1000)
    localparam logic [27:0] MS_RECIP  = 28'd137438953;

    function automatic logic [18:0] unit_us(input t_unit u);
        logic [18:0] v;
        case (u)
            UNIT_64:     v = 19'd64;
            UNIT_4100:   v = 19'd4100;
            UNIT_262000: v = 19'd262000;
            default:     v = 19'd64;
        endcase
        return v;
    endfunction

    // half a unit less one: biases the floor so that an exact half rounds down
    function automatic logic [16:0] unit_ofs(input t_unit u);
        logic [16:0] v;
        case (u)
            UNIT_64:     v = 17'd31;
            UNIT_4100:   v = 17'd2049;
            UNIT_262000: v = 17'd130999;
            default:     v = 17'd31;
        endcase
        return v;
    endfunction

    // floor(2^32 / unit)
    function automatic logic [26:0] unit_recip(input t_unit u);
        logic [26:0] v;
        case (u)
            UNIT_64:     v = 27'd67108864;
            UNIT_4100:   v = 27'd1047552;
            UNIT_262000: v = 27'd16393;
            default:     v = 27'd67108864;
        endcase
        return v;
    endfunction

endpackage

// ===== src/lde_quant.sv =====
// ---------------------------------------------------------------------------
// Listen duration quantiser
// Four-stage pipeline: pick the unit, divide by reciprocal, multiply back, correct.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lde_quant (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [31:0]           i_dur,
    output logic                  o_valid,
    output lde_pkg::t_quant       o_q
);

    logic                r_v1, r_v2, r_v3, r_v4;
    logic                r_ok1, r_ok2, r_ok3;
    lde_pkg::t_unit      r_unit1, r_unit2, r_unit3;
    logic [25:0]         r_n1, r_n2, r_n3;
    logic [7:0]          r_qe2, r_qe3;
    logic [25:0]         r_est3;
    lde_pkg::t_quant     r_q4;

    lde_pkg::t_unit      n_unit1;
    logic [25:0]         n_n1;
    logic [52:0]         n_prod2;
    logic [26:0]         n_est3;
    logic [25:0]         n_rem4;
    logic [25:0]         n_u4;
    logic                n_corr4;
    lde_pkg::t_quant     n_q4;

    // stage 1: choose the first unit that fits, bias the numerator
    always_comb begin
        if (i_dur <= lde_pkg::FIT_MAX_64) begin
            n_unit1 = lde_pkg::UNIT_64;
        end else if (i_dur <= lde_pkg::FIT_MAX_4100) begin
            n_unit1 = lde_pkg::UNIT_4100;
        end else begin
            n_unit1 = lde_pkg::UNIT_262000;
        end
        n_n1 = i_dur[25:0] + {9'd0, lde_pkg::unit_ofs(n_unit1)};
    end

    always_ff @(posedge i_clk) begin
        r_ok1   <= (i_dur <= lde_pkg::FIT_MAX_262000);
        r_unit1 <= n_unit1;
        r_n1    <= n_n1;
    end

    // stage 2: quotient estimate, low by at most one
    assign n_prod2 = {1'b0, r_n1} * {26'd0, lde_pkg::unit_recip(r_unit1)};

    always_ff @(posedge i_clk) begin
        r_ok2   <= r_ok1;
        r_unit2 <= r_unit1;
        r_n2    <= r_n1;
        r_qe2   <= n_prod2[39:32];
    end

    // stage 3: estimate back to microseconds
    assign n_est3 = {19'd0, r_qe2} * {8'd0, lde_pkg::unit_us(r_unit2)};

    always_ff @(posedge i_clk) begin
        r_ok3   <= r_ok2;
        r_unit3 <= r_unit2;
        r_n3    <= r_n2;
        r_qe3   <= r_qe2;
        r_est3  <= n_est3[25:0];
    end

    // stage 4: step the estimate up where a whole unit is left over
    always_comb begin
        n_u4      = {7'd0, lde_pkg::unit_us(r_unit3)};
        n_rem4    = r_n3 - r_est3;
        n_corr4   = (n_rem4 >= n_u4);
        n_q4.ok   = r_ok3;
        n_q4.unit = r_unit3;
        if (n_corr4) begin
            n_q4.count  = r_qe3 + 8'd1;
            n_q4.actual = r_est3 + n_u4;
        end else begin
            n_q4.count  = r_qe3;
            n_q4.actual = r_est3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q4 <= n_q4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_valid = r_v4;
    assign o_q     = r_q4;

endmodule

// ===== src/listen_duration_encoder.sv =====
// ---------------------------------------------------------------------------
// Listen duration encoder
// Encodes receive and idle windows into unit/count form with cycle length.
// ---------------------------------------------------------------------------
// Usage:
//   Drive a request word on i_req and raise start for one cycle per word.
//   busy stays low: a new word is taken on every cycle, back to back.
//   Each word gives one result word on o_res, marked by o_valid for exactly
//   one cycle, once the word has passed through every pipeline stage.
//   Throughput is one word per cycle; each word passes through the eight
//   pipeline stages: unit choice, reciprocal multiply, back-multiply and
//   correction for each duration, then sum, reciprocal multiply,
//   back-multiply and correction for the cycle length in ms.
//   Each duration takes the first of 64 us, 4100 us and 262000 us whose
//   rounded count (half rounds down) is below 256. If either duration fits
//   no unit, ok is low and every other field is zero.
//   Synchronous reset drops all words in flight; no result appears in the
//   cycle after reset. The receiver cannot stall: a result not taken in its
//   cycle is gone.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "listen_duration_encoder_macros.svh"

module listen_duration_encoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  lde_pkg::t_req     i_req,
    output logic              busy,
    output logic              o_valid,
    output lde_pkg::t_res     o_res
);

    logic               w_rx_v, w_idle_v;
    lde_pkg::t_quant    w_rx_q, w_idle_q;

    logic               r_v5, r_v6, r_v7, r_v8;
    lde_pkg::t_res      r_res5, r_res6, r_res7, r_res8;
    logic [26:0]        r_sum5, r_sum6, r_sum7;
    logic [17:0]        r_qe6, r_qe7;
    logic [26:0]        r_est7;

    lde_pkg::t_res      n_res5;
    logic               n_ok5;
    logic [54:0]        n_prod6;
    logic [27:0]        n_est7;
    logic [26:0]        n_rem8;
    lde_pkg::t_res      n_res8;

    assign busy = 1'b0;

    lde_quant u_rx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_dur   (i_req.rx_request_us),
        .o_valid (w_rx_v),
        .o_q     (w_rx_q)
    );

    lde_quant u_idle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_dur   (i_req.idle_request_us),
        .o_valid (w_idle_v),
        .o_q     (w_idle_q)
    );

    // stage 5: merge, clear the fields of a failed word, sum the windows
    always_comb begin
        n_ok5 = w_rx_q.ok & w_idle_q.ok;
        n_res5 = '0;
        if (n_ok5) begin
            n_res5.ok             = 1'b1;
            n_res5.rx_unit        = w_rx_q.unit;
            n_res5.rx_count       = w_rx_q.count;
            n_res5.idle_unit      = w_idle_q.unit;
            n_res5.idle_count     = w_idle_q.count;
            n_res5.rx_actual_us   = w_rx_q.actual;
            n_res5.idle_actual_us = w_idle_q.actual;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res5 <= n_res5;
        r_sum5 <= {1'b0, n_res5.rx_actual_us} + {1'b0, n_res5.idle_actual_us};
    end

    // stage 6: ms estimate, low by at most one
    assign n_prod6 = {1'b0, r_sum5} * {27'd0, lde_pkg::MS_RECIP};

    always_ff @(posedge i_clk) begin
        r_res6 <= r_res5;
        r_sum6 <= r_sum5;
        r_qe6  <= n_prod6[54:37];
    end

    // stage 7: estimate back to microseconds
    assign n_est7 = {10'd0, r_qe6} * {18'd0, lde_pkg::US_PER_MS};

    always_ff @(posedge i_clk) begin
        r_res7 <= r_res6;
        r_sum7 <= r_sum6;
        r_qe7  <= r_qe6;
        r_est7 <= n_est7[26:0];
    end

    // stage 8: correct the estimate
    always_comb begin
        n_rem8 = r_sum7 - r_est7;
        n_res8 = r_res7;
        if (n_rem8 >= {17'd0, lde_pkg::US_PER_MS}) begin
            n_res8.cycle_ms = r_qe7 + 18'd1;
        end else begin
            n_res8.cycle_ms = r_qe7;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res8 <= n_res8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            r_v5 <= w_rx_v & w_idle_v;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    assign o_valid = r_v8;
    assign o_res   = r_res8;

    `LDE_ASSERT(a_latency, i_clk, i_rst_n, start |-> ##8 o_valid, "result word missing")
    `LDE_ASSERT(a_fail_zero, i_clk, i_rst_n, (o_valid && !o_res.ok) |-> (o_res.cycle_ms == 18'd0 && o_res.rx_actual_us == 26'd0 && o_res.idle_count == 8'd0), "failed word not cleared")
    `LDE_ASSERT(a_unit64_exact, i_clk, i_rst_n, (o_valid && o_res.ok && o_res.rx_unit == lde_pkg::UNIT_64) |-> (o_res.rx_actual_us == (26'(o_res.rx_count) << 6)), "64 us quantisation wrong")
    `LDE_ASSERT_ALWAYS(a_reset_flush, i_clk, !i_rst_n |=> !o_valid, "word survived reset")

endmodule
